// File: rtl/core/ssi_pkg.sv
// shared constants for the segment/sphere intersection unit
`timescale 1ns / 1ps
package ssi_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int RADIUS_W        = 32;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 32'h0001_0000;
    localparam int LIMB_W          = 32;
endpackage

// File: rtl/core/ssi_seg_if.sv
// segment/sphere query channel
`timescale 1ns / 1ps
interface ssi_seg_if #(parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] seg_start_x;
    logic signed [COORD_WIDTH-1:0] seg_start_y;
    logic signed [COORD_WIDTH-1:0] seg_start_z;
    logic signed [COORD_WIDTH-1:0] seg_vec_x;
    logic signed [COORD_WIDTH-1:0] seg_vec_y;
    logic signed [COORD_WIDTH-1:0] seg_vec_z;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;

    modport source (output valid, seg_start_x, seg_start_y, seg_start_z,
                    seg_vec_x, seg_vec_y, seg_vec_z, center_x, center_y, center_z,
                    input ready);
    modport sink (input valid, seg_start_x, seg_start_y, seg_start_z,
                  seg_vec_x, seg_vec_y, seg_vec_z, center_x, center_y, center_z,
                  output ready);
endinterface

// File: rtl/core/ssi_hit_if.sv
// hit result channel
`timescale 1ns / 1ps
interface ssi_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

// File: rtl/core/ssi_wide_mul.sv
// three-stage unsigned wide multiplier built from limb partial products
`timescale 1ns / 1ps
module ssi_wide_mul #(
    parameter int AW = 67,
    parameter int BW = 67
) (
    input  logic                 clk,
    input  logic [2:0]           en,
    input  logic [AW-1:0]        a,
    input  logic [BW-1:0]        b,
    output logic [AW+BW-1:0]     prod
);
    localparam int L   = ssi_pkg::LIMB_W;
    localparam int NA  = (AW + L - 1) / L;
    localparam int NB  = (BW + L - 1) / L;
    localparam int PRW = (NA + NB) * L;

    logic [NA*L-1:0]  ax;
    logic [NB*L-1:0]  bx;
    logic [2*L-1:0]   pp_reg [NA][NB];
    logic [PRW-1:0]   row_next [NA];
    logic [PRW-1:0]   row_reg [NA];
    logic [PRW-1:0]   sum_next;
    logic [AW+BW-1:0] prod_reg;

    assign ax = (NA*L)'(a);
    assign bx = (NB*L)'(b);

    // one row per limb of a
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (PRW'(pp_reg[i][j]) << (j * L));
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            sum_next = sum_next + (row_reg[i] << (i * L));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= ax[i*L +: L] * bx[j*L +: L];
                end
            end
        end
        if (en[1])
        begin
            for (int i = 0; i < NA; i++)
            begin
                row_reg[i] <= row_next[i];
            end
        end
        if (en[2])
        begin
            prod_reg <= sum_next[AW+BW-1:0];
        end
    end

    assign prod = prod_reg;
endmodule

// File: rtl/core/segment_sphere_intersect_unit.sv
// segment against sphere touch test, eight-stage pipeline
// One query (segment start, segment vector, sphere centre) enters per cycle and its hit
// flag leaves the last stage; throughput is one per cycle unless the output stalls,
// set by the fully pipelined datapath: difference, component products, dot-product
// sums, c and |p|, then a three-stage limb multiplier for p*p and c*q, then the final
// decision. Each stage holds its item until the next stage frees, so bubbles close up
// and a stalled output does not block the input until every stage is full. The squared
// radius (unsigned, FRAC_BITS fractional bits, reset 1.0 at 16 fractional bits) is
// written through cfg_we/cfg_wdata and must only change while no query is in flight.
// The test is exact: no rounding or saturation anywhere; a zero-length segment hits
// only when its start lies in or on the sphere.
`timescale 1ns / 1ps
module segment_sphere_intersect_unit #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ssi_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ssi_seg_if.sink                       req,
    ssi_hit_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [ssi_pkg::RADIUS_W-1:0]  cfg_wdata
);
    localparam int W    = COORD_WIDTH;
    localparam int MW   = W + 1;           // m = start - centre
    localparam int MDW  = 2 * W + 1;       // m*d
    localparam int DDW  = 2 * W;           // d*d
    localparam int MMCW = 2 * W + 2;       // m*m per component
    localparam int PW   = 2 * W + 3;       // p = m.d
    localparam int QW   = 2 * W + 2;       // q = d.d
    localparam int MMW  = 2 * W + 4;       // m.m
    localparam int R2W  = ssi_pkg::RADIUS_W + FRAC_BITS;
    localparam int CW   = ((MMW > R2W) ? MMW : R2W) + 1;
    localparam int SW   = CW + 3;          // room for 2p + q + c
    localparam int NST  = 8;
    localparam int XW   = (2 * PW > (CW + QW - 2)) ? 2 * PW : (CW + QW - 2);

    typedef struct packed {
        logic qz;        // zero-length segment
        logic cpos;      // start outside sphere
        logic ppos;      // heading away
        logic pqnn;      // p + q >= 0
        logic lastpos;   // 2p + q + c > 0
    } flags_t;

    logic [ssi_pkg::RADIUS_W-1:0] radius_reg;
    logic [NST-1:0]               v_reg;
    logic [NST-1:0]               en;

    // stage payloads
    logic signed [MW-1:0]   m_reg  [3];
    logic signed [W-1:0]    d_reg  [3];
    logic signed [MDW-1:0]  md_reg [3];
    logic signed [DDW-1:0]  dd_reg [3];
    logic signed [MMCW-1:0] mm_reg [3];
    logic signed [PW-1:0]   p_reg;
    logic signed [QW-1:0]   q_reg;
    logic signed [MMW-1:0]  mms_reg;
    logic signed [PW-1:0]   p4_reg;
    logic signed [QW-1:0]   q4_reg;
    logic signed [CW-1:0]   c4_reg;
    logic [PW-1:0]          pabs4_reg;
    flags_t                 f5_reg, f6_reg, f7_reg;
    flags_t                 f_next;
    logic                   hit_reg;
    logic                   hit_next;

    logic signed [W-1:0]    st [3];
    logic signed [W-1:0]    dv [3];
    logic signed [W-1:0]    ce [3];
    logic signed [SW-1:0]   pq_sum;
    logic signed [SW-1:0]   last_sum;
    logic [2*PW-1:0]        psq;
    logic [CW+QW-3:0]       cq;

    assign st[0] = req.seg_start_x;
    assign st[1] = req.seg_start_y;
    assign st[2] = req.seg_start_z;
    assign dv[0] = req.seg_vec_x;
    assign dv[1] = req.seg_vec_y;
    assign dv[2] = req.seg_vec_z;
    assign ce[0] = req.center_x;
    assign ce[1] = req.center_y;
    assign ce[2] = req.center_z;

    // stage advances when empty or when the next one advances
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || rsp.ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign req.ready = en[0];
    assign rsp.valid = v_reg[NST-1];
    assign rsp.hit   = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= ssi_pkg::RADIUS_RESET;
            v_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            if (en[0])
            begin
                v_reg[0] <= req.valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // decision flags from stage 4
    always_comb
    begin
        pq_sum         = SW'(p4_reg) + SW'(q4_reg);
        last_sum       = SW'(p4_reg) + SW'(p4_reg) + SW'(q4_reg) + SW'(c4_reg);
        f_next.qz      = (q4_reg == '0);
        f_next.cpos    = (c4_reg > 0);
        f_next.ppos    = (p4_reg > 0);
        f_next.pqnn    = !pq_sum[SW-1];
        f_next.lastpos = (last_sum > 0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_reg[k] <= MW'(st[k]) - MW'(ce[k]);
                d_reg[k] <= dv[k];
            end
        end
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                md_reg[k] <= MDW'(m_reg[k]) * MDW'(d_reg[k]);
                dd_reg[k] <= DDW'(d_reg[k]) * DDW'(d_reg[k]);
                mm_reg[k] <= MMCW'(m_reg[k]) * MMCW'(m_reg[k]);
            end
        end
        if (en[2])
        begin
            p_reg   <= PW'(md_reg[0]) + PW'(md_reg[1]) + PW'(md_reg[2]);
            q_reg   <= QW'(dd_reg[0]) + QW'(dd_reg[1]) + QW'(dd_reg[2]);
            mms_reg <= MMW'(mm_reg[0]) + MMW'(mm_reg[1]) + MMW'(mm_reg[2]);
        end
        if (en[3])
        begin
            p4_reg    <= p_reg;
            q4_reg    <= q_reg;
            c4_reg    <= CW'(mms_reg)
                         - CW'($signed({1'b0, radius_reg, {FRAC_BITS{1'b0}}}));
            pabs4_reg <= p_reg[PW-1] ? PW'(-p_reg) : PW'(p_reg);
        end
        if (en[4])
        begin
            f5_reg <= f_next;
        end
        if (en[5])
        begin
            f6_reg <= f5_reg;
        end
        if (en[6])
        begin
            f7_reg <= f6_reg;
        end
        if (en[7])
        begin
            hit_reg <= hit_next;
        end
    end

    // p*p and c*q, c taken only where positive
    ssi_wide_mul #(.AW(PW), .BW(PW)) u_mul_pp (
        .clk  (clk),
        .en   (en[6:4]),
        .a    (pabs4_reg),
        .b    (pabs4_reg),
        .prod (psq)
    );

    ssi_wide_mul #(.AW(CW - 1), .BW(QW - 1)) u_mul_cq (
        .clk  (clk),
        .en   (en[6:4]),
        .a    (c4_reg[CW-2:0]),
        .b    (q4_reg[QW-2:0]),
        .prod (cq)
    );

    always_comb
    begin
        if (f7_reg.qz)
        begin
            hit_next = !f7_reg.cpos;
        end
        else if (f7_reg.cpos && f7_reg.ppos)
        begin
            hit_next = 1'b0;
        end
        else if (f7_reg.cpos && (XW'(psq) < XW'(cq)))
        begin
            hit_next = 1'b0;
        end
        else if (f7_reg.pqnn)
        begin
            hit_next = 1'b1;
        end
        else
        begin
            hit_next = !f7_reg.lastpos;
        end
    end
endmodule

// File: rtl/core/ssi_checker.sv
// port-level checks for the segment/sphere intersection unit
`timescale 1ns / 1ps
module ssi_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic hit
);
    logic [3:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_reg + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit))
        else $error("result dropped or changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != 4'd0)
        else $error("result with no query in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 4'd8)
        else $error("more queries in flight than pipeline stages");

    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < 4'd8 |-> in_ready)
        else $error("input held off with free stages");
endmodule

bind segment_sphere_intersect_unit ssi_checker u_ssi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .hit       (rsp.hit)
);
